// ===== src/key_press_duration_classifier_assert.svh =====
// assertion macros for the key press duration classifier
// used by the top level, no other dependencies
`ifndef KEY_PRESS_DURATION_CLASSIFIER_ASSERT_SVH
`define KEY_PRESS_DURATION_CLASSIFIER_ASSERT_SVH

// same-cycle implication, muted during reset
`define KPDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kpdc assertion failed");

// next-cycle implication, muted during reset
`define KPDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kpdc assertion failed");

`endif

// ===== src/kpdc_pkg.sv =====
// shared types and constants of the key press duration classifier
// no dependencies
package kpdc_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  localparam int TYPE_W  = 5;
  localparam int CODE_W  = 16;
  localparam int VAL_W   = 2;
  localparam int TS_W    = 64;
  localparam int CLS_W   = 2;
  localparam int THR_W   = 40;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 64;
  localparam int IN_DW   = 88;
  localparam int OUT_DW  = 24;

  localparam logic [TYPE_W-1:0] EVENT_KEY   = TYPE_W'(1);
  localparam logic [VAL_W-1:0]  VAL_RELEASE = VAL_W'(0);
  localparam logic [VAL_W-1:0]  VAL_PRESS   = VAL_W'(1);

  localparam logic [CLS_W-1:0] CLASS_SHORT   = CLS_W'(0);
  localparam logic [CLS_W-1:0] CLASS_LONG    = CLS_W'(1);
  localparam logic [CLS_W-1:0] CLASS_ALWAYS  = CLS_W'(2);
  localparam logic [CLS_W-1:0] CLASS_INVALID = CLS_W'(3);

  localparam logic [1:0] REG_SHORT_MAX  = 2'd0;
  localparam logic [1:0] REG_LONG_MIN   = 2'd1;
  localparam logic [1:0] REG_LONG_MAX   = 2'd2;
  localparam logic [1:0] REG_ALWAYS_MIN = 2'd3;

  localparam logic [THR_W-1:0] RST_SHORT_MAX  = THR_W'(64'd600000000);
  localparam logic [THR_W-1:0] RST_LONG_MIN   = THR_W'(64'd2000000000);
  localparam logic [THR_W-1:0] RST_LONG_MAX   = THR_W'(64'd7000000000);
  localparam logic [THR_W-1:0] RST_ALWAYS_MIN = THR_W'(64'd10000000000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUB,
    ST_CMP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [THR_W-1:0] short_max;
    logic [THR_W-1:0] long_min;
    logic [THR_W-1:0] long_max;
    logic [THR_W-1:0] always_min;
  } cfg_t;

  typedef struct packed {
    logic [TS_W-1:0] a;
    logic [TS_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic            borrow;
    logic [TS_W-1:0] diff;
  } alu_rsp_t;

endpackage

// ===== src/key_press_duration_classifier.sv =====
// top level: slot table, scan sequencer and result register
// flow: accept, scan the slots in order (up to KEY_SLOTS), then issue; a release adds one
// subtract and four compares on the shared subtractor; a key value other than press or release
// issues with no scan; a scan with no hit and a non-key event issue nothing; a new request is
// taken only in idle, once the last one ends, and also while the last result waits; reset clears
// the table and loads the default thresholds, slot times stay unset until a press writes them
module key_press_duration_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // key_code[15:0], key_value[17:16], timestamp_ns[81:18], zero pad
  input  logic [kpdc_pkg::IN_DW-1:0]    s_axis_tdata,
  // event_type[4:0]
  input  logic [kpdc_pkg::TYPE_W-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_key_code[15:0], out_key_value[17:16], press_class[19:18], zero pad
  output logic [kpdc_pkg::OUT_DW-1:0]   m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kpdc_pkg::CFG_AW-1:0]   paddr,
  input  logic [kpdc_pkg::CFG_DW-1:0]   pwdata,
  output logic [kpdc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import kpdc_pkg::*;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  state_e state_q, state_d;

  logic [CODE_W-1:0] code_q;
  logic [VAL_W-1:0]  val_q;
  logic [TS_W-1:0]   ts_q;
  logic [TS_W-1:0]   hold_q;
  logic [SLOT_W-1:0] idx_q;
  logic [1:0]        step_q;
  logic [3:0]        flags_q;

  logic [KEY_SLOTS-1:0] in_use_q;
  logic [CODE_W-1:0]    slot_code_q [KEY_SLOTS];
  logic [TS_W-1:0]      slot_time_q [KEY_SLOTS];

  logic              out_valid_q;
  logic [CODE_W-1:0] out_code_q;
  logic [VAL_W-1:0]  out_val_q;
  logic [CLS_W-1:0]  out_cls_q;

  logic              in_acc;
  logic              is_press;
  logic              is_release;
  logic              in_key;
  logic [VAL_W-1:0]  in_val;
  logic              hit;
  logic              last_slot;
  logic              out_free;
  logic [CLS_W-1:0]  cls;

  kpdc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kpdc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_acc     = s_axis_tvalid & s_axis_tready;
  assign in_key     = (s_axis_tuser == EVENT_KEY);
  assign in_val     = s_axis_tdata[17:16];
  assign is_press   = (val_q == VAL_PRESS);
  assign is_release = (val_q == VAL_RELEASE);
  assign last_slot  = (idx_q == SLOT_W'(KEY_SLOTS - 1));
  assign out_free   = ~out_valid_q | m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_key) begin
          if (in_val == VAL_PRESS || in_val == VAL_RELEASE) state_d = ST_SCAN;
          else state_d = ST_FIN;
        end
      end
      ST_SCAN: begin
        if (hit) state_d = is_press ? ST_FIN : ST_SUB;
        else if (last_slot) state_d = ST_IDLE;
      end
      ST_SUB: state_d = ST_CMP;
      ST_CMP: begin
        if (step_q == 2'd3) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    s_axis_tready = 1'b0;
    hit           = 1'b0;
    alu_req.a     = ts_q;
    alu_req.b     = slot_time_q[idx_q];
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_SCAN: begin
        if (is_press) hit = ~in_use_q[idx_q];
        else hit = in_use_q[idx_q] & (slot_code_q[idx_q] == code_q);
      end
      ST_CMP: begin
        case (step_q)
          2'd0: begin
            alu_req.a = TS_W'(cfg.short_max);
            alu_req.b = hold_q;
          end
          2'd1: begin
            alu_req.a = hold_q;
            alu_req.b = TS_W'(cfg.long_min);
          end
          2'd2: begin
            alu_req.a = TS_W'(cfg.long_max);
            alu_req.b = hold_q;
          end
          default: begin
            alu_req.a = hold_q;
            alu_req.b = TS_W'(cfg.always_min);
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    if (!is_release) cls = CLASS_SHORT;
    else if (flags_q[0]) cls = CLASS_SHORT;
    else if (flags_q[1] && flags_q[2]) cls = CLASS_LONG;
    else if (flags_q[3]) cls = CLASS_ALWAYS;
    else cls = CLASS_INVALID;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      step_q      <= '0;
      in_use_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slot_code_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: idx_q <= '0;
        ST_SCAN: begin
          if (hit) begin
            in_use_q[idx_q]    <= is_press;
            slot_code_q[idx_q] <= is_press ? code_q : '0;
          end else if (!last_slot) begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        ST_SUB: step_q <= '0;
        ST_CMP: step_q <= step_q + 2'd1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q <= s_axis_tdata[15:0];
      val_q  <= in_val;
      ts_q   <= s_axis_tdata[81:18];
    end
    if (state_q == ST_SCAN && hit && is_press) slot_time_q[idx_q] <= ts_q;
    if (state_q == ST_SUB) hold_q <= alu_rsp.diff;
    if (state_q == ST_CMP) flags_q[step_q] <= ~alu_rsp.borrow;
    if (state_q == ST_FIN && out_free) begin
      out_code_q <= code_q;
      out_val_q  <= val_q;
      out_cls_q  <= cls;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_cls_q, out_val_q, out_code_q};

`include "key_press_duration_classifier_assert.svh"

  `KPDC_ASSERT_IMP(a_out_from_fin, $rose(m_axis_tvalid), $past(state_q == ST_FIN))
  `KPDC_ASSERT_IMP(a_class_only_release, out_valid_q && (out_val_q != VAL_RELEASE), out_cls_q == CLASS_SHORT)
  `KPDC_ASSERT_NXT(a_press_claims, state_q == ST_SCAN && hit && is_press, in_use_q[$past(idx_q)])

endmodule

// ===== src/kpdc_cfg.sv =====
// threshold registers behind the apb-style configuration port
// depends on kpdc_pkg
module kpdc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kpdc_pkg::CFG_AW-1:0]   paddr,
  input  logic [kpdc_pkg::CFG_DW-1:0]   pwdata,
  output logic [kpdc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output kpdc_pkg::cfg_t                cfg_o
);
  import kpdc_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:3];
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_max  <= RST_SHORT_MAX;
      cfg_q.long_min   <= RST_LONG_MIN;
      cfg_q.long_max   <= RST_LONG_MAX;
      cfg_q.always_min <= RST_ALWAYS_MIN;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SHORT_MAX:  cfg_q.short_max  <= pwdata[THR_W-1:0];
        REG_LONG_MIN:   cfg_q.long_min   <= pwdata[THR_W-1:0];
        REG_LONG_MAX:   cfg_q.long_max   <= pwdata[THR_W-1:0];
        REG_ALWAYS_MIN: cfg_q.always_min <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SHORT_MAX:  prdata = CFG_DW'(cfg_q.short_max);
      REG_LONG_MIN:   prdata = CFG_DW'(cfg_q.long_min);
      REG_LONG_MAX:   prdata = CFG_DW'(cfg_q.long_max);
      REG_ALWAYS_MIN: prdata = CFG_DW'(cfg_q.always_min);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== src/kpdc_alu.sv =====
// shared 64-bit subtractor, gives difference and borrow
// used for the hold time and for every threshold compare; depends on kpdc_pkg
module kpdc_alu (
  input  kpdc_pkg::alu_req_t req_i,
  output kpdc_pkg::alu_rsp_t rsp_o
);
  import kpdc_pkg::*;

  logic [TS_W:0] full;

  assign full         = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign rsp_o.diff   = full[TS_W-1:0];
  assign rsp_o.borrow = full[TS_W];

endmodule
